/* hw/rtl/cvcl_pkg.sv */
`timescale 1ns / 1ps

package cvcl_pkg;

    // Error sum width; everything that depends on it is derived below.
    localparam int ESB         = 48;
    localparam int CHUNK_BITS  = 24;
    localparam int NCH         = (ESB + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_W       = NCH * CHUNK_BITS;
    localparam int K_W         = (NCH > 1) ? $clog2(NCH) : 1;

    // Shared multiplier: 33 bit signed by 25 bit signed.
    localparam int MA_W        = 33;
    localparam int MB_W        = 25;
    localparam int MP_W        = MA_W + MB_W;

    // Integral term: the full gain times error sum product, then the term itself.
    localparam int ACC_W       = ESB + 33;
    localparam int IW          = (ESB + 1 > 42) ? ESB + 1 : 42;
    localparam int ITERM_W     = 42;
    localparam int P_W         = 25;
    localparam int RAW_W       = 43;
    localparam int IE_W        = 17;
    localparam int ADJ_W       = 41;
    localparam int ND_W        = 43;
    localparam int DUTY_W      = 33;

    localparam logic [DUTY_W-1:0] DUTY_ONE   = 33'h1_0000_0000;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 33'd1430224110;

    // Register reset values.
    localparam logic signed [15:0] VT_RESET  = -16'sd3072;
    localparam logic [14:0]        LIM_RESET = 15'd1280;
    localparam logic [23:0]        KP_RESET  = 24'd3277;
    localparam logic [31:0]        KI_RESET  = 32'd85899;
    localparam logic [31:0]        KC_RESET  = 32'd12885;

    typedef enum logic [2:0] {
        REG_VOLTAGE_TARGET      = 3'd0,
        REG_CURRENT_LIMIT       = 3'd1,
        REG_VOLTAGE_PROP_GAIN   = 3'd2,
        REG_VOLTAGE_INT_GAIN_DT = 3'd3,
        REG_CURRENT_GAIN_DT     = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] voltage_target;
        logic [14:0]        current_limit;
        logic [23:0]        voltage_prop_gain;
        logic [31:0]        voltage_int_gain_dt;
        logic [31:0]        current_gain_dt;
    } cfg_t;

endpackage

/* hw/rtl/cvcl_regs.sv */
`timescale 1ns / 1ps

module cvcl_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output cvcl_pkg::cfg_t  cfg
);
    import cvcl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.voltage_target      <= VT_RESET;
            cfg_reg.current_limit       <= LIM_RESET;
            cfg_reg.voltage_prop_gain   <= KP_RESET;
            cfg_reg.voltage_int_gain_dt <= KI_RESET;
            cfg_reg.current_gain_dt     <= KC_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VOLTAGE_TARGET:      cfg_reg.voltage_target      <= signed'(cfg_data[15:0]);
                REG_CURRENT_LIMIT:       cfg_reg.current_limit       <= cfg_data[14:0];
                REG_VOLTAGE_PROP_GAIN:   cfg_reg.voltage_prop_gain   <= cfg_data[23:0];
                REG_VOLTAGE_INT_GAIN_DT: cfg_reg.voltage_int_gain_dt <= cfg_data;
                REG_CURRENT_GAIN_DT:     cfg_reg.current_gain_dt     <= cfg_data;
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/cvcl_mul.sv */
`timescale 1ns / 1ps

module cvcl_mul (
    input  logic                                 aclk,
    input  logic signed [cvcl_pkg::MA_W-1:0]     op_a,
    input  logic signed [cvcl_pkg::MB_W-1:0]     op_b,
    output logic signed [cvcl_pkg::MP_W-1:0]     prod
);
    import cvcl_pkg::*;

    logic signed [MP_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MP_W'(op_a) * MP_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/cascaded_voltage_current_loop_top.sv */
`timescale 1ns / 1ps
// Each input item runs through ERR, PMUL, PGET, one IMUL/IACC pass per chunk of the
// error sum (NCH = 2 multiplier passes with a 48 bit error sum), ITERM, CLAMP, CMUL and DUTY.
// A new item is accepted only after the result has been taken;
// the single shared 33x25 multiplier is used four times per item.
// Reset (aresetn, synchronous, active low) restores the registers, clears the error
// sum and loads the duty value with 0.333; the block is ready in the next cycle.
module cascaded_voltage_current_loop_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_vout_sample,
    input  logic signed [15:0]  s_inductor_current_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [32:0]         m_duty_cycle,
    output logic signed [15:0]  m_current_reference,
    output logic                m_current_limited,
    output logic                m_duty_saturated,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import cvcl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_PMUL,
        ST_PGET,
        ST_IMUL,
        ST_IACC,
        ST_ITERM,
        ST_CLAMP,
        ST_CMUL,
        ST_DUTY,
        ST_DONE
    } state_t;

    cfg_t                    cfg;
    state_t                  state_reg;
    logic                    m_valid_reg;
    logic signed [15:0]      vout_reg;
    logic signed [15:0]      il_reg;
    logic signed [IE_W-1:0]  e_reg;
    logic signed [ESB-1:0]   es_reg;
    logic signed [P_W-1:0]   p_reg;
    logic [K_W-1:0]          k_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic signed [IE_W-1:0]  ie_reg;
    logic [DUTY_W-1:0]       duty_reg;
    logic signed [15:0]      ref_reg;
    logic                    climit_reg;
    logic                    dsat_reg;

    logic signed [MA_W-1:0]    op_a;
    logic signed [MB_W-1:0]    op_b;
    logic signed [MP_W-1:0]    prod;

    logic signed [IE_W-1:0]    e_now;
    logic signed [ESB:0]       es_sum;
    logic signed [ESB-1:0]     es_sat;
    logic signed [PAD_W-1:0]   es_pad;
    logic [CHUNK_BITS-1:0]     chunk;
    logic signed [IW-1:0]      i_ext;
    logic signed [ITERM_W-1:0] i_cap;
    logic signed [15:0]        lim16;
    logic signed [15:0]        ref_now;
    logic                      climit_now;
    logic signed [ADJ_W-1:0]   adj;
    logic signed [ND_W-1:0]    nd;
    logic [DUTY_W-1:0]         duty_now;
    logic                      dsat_now;

    cvcl_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cvcl_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Voltage error and saturating error sum.
    always_comb begin
        e_now  = IE_W'(cfg.voltage_target) - IE_W'(vout_reg);
        es_sum = (ESB + 1)'(es_reg) + (ESB + 1)'(e_now);
        if (es_sum[ESB] != es_sum[ESB-1]) begin
            es_sat = es_sum[ESB] ? {1'b1, {(ESB - 1){1'b0}}} : {1'b0, {(ESB - 1){1'b1}}};
        end else begin
            es_sat = es_sum[ESB-1:0];
        end
    end

    // The error sum enters the multiplier one chunk at a time, top chunk first;
    // only the top chunk carries the sign.
    assign es_pad = PAD_W'(es_reg);
    assign chunk  = es_pad[k_reg * CHUNK_BITS +: CHUNK_BITS];

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_PMUL: begin
                op_a = signed'({{(MA_W - 24){1'b0}}, cfg.voltage_prop_gain});
                op_b = MB_W'(e_reg);
            end
            ST_IMUL: begin
                op_a = signed'({1'b0, cfg.voltage_int_gain_dt});
                if (k_reg == K_W'(NCH - 1)) begin
                    op_b = signed'({chunk[CHUNK_BITS-1], chunk});
                end else begin
                    op_b = signed'({1'b0, chunk});
                end
            end
            ST_CMUL: begin
                op_a = signed'({1'b0, cfg.current_gain_dt});
                op_b = MB_W'(ie_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Integral term: floor of the product over 2^32, held within +/- 2^40.
    always_comb begin
        i_ext = IW'(signed'(acc_reg[ACC_W-1:32]));
        if (i_ext > (IW'(1) <<< 40)) begin
            i_cap = ITERM_W'(1) <<< 40;
        end else if (i_ext < -(IW'(1) <<< 40)) begin
            i_cap = -(ITERM_W'(1) <<< 40);
        end else begin
            i_cap = i_ext[ITERM_W-1:0];
        end
    end

    // Current reference clamp; a value equal to a bound does not flag.
    always_comb begin
        lim16 = signed'({1'b0, cfg.current_limit});
        climit_now = 1'b0;
        if (raw_reg > RAW_W'(lim16)) begin
            ref_now    = lim16;
            climit_now = 1'b1;
        end else if (raw_reg < -RAW_W'(lim16)) begin
            ref_now    = -lim16;
            climit_now = 1'b1;
        end else begin
            ref_now = raw_reg[15:0];
        end
    end

    // Duty update from the current loop product.
    always_comb begin
        adj      = prod[ADJ_W+7:8];
        nd       = ND_W'(signed'({1'b0, duty_reg})) + ND_W'(adj);
        dsat_now = 1'b0;
        if (nd > ND_W'(signed'({1'b0, DUTY_ONE}))) begin
            duty_now = DUTY_ONE;
            dsat_now = 1'b1;
        end else if (nd < 0) begin
            duty_now = '0;
            dsat_now = 1'b1;
        end else begin
            duty_now = nd[DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            es_reg      <= '0;
            duty_reg    <= DUTY_RESET;
            k_reg       <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        vout_reg  <= s_vout_sample;
                        il_reg    <= s_inductor_current_sample;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    e_reg     <= e_now;
                    es_reg    <= es_sat;
                    state_reg <= ST_PMUL;
                end
                ST_PMUL: begin
                    state_reg <= ST_PGET;
                end
                ST_PGET: begin
                    p_reg     <= prod[P_W+15:16];
                    k_reg     <= K_W'(NCH - 1);
                    acc_reg   <= '0;
                    state_reg <= ST_IMUL;
                end
                ST_IMUL: begin
                    state_reg <= ST_IACC;
                end
                ST_IACC: begin
                    acc_reg <= ACC_W'(acc_reg <<< CHUNK_BITS) + ACC_W'(prod);
                    if (k_reg == '0) begin
                        state_reg <= ST_ITERM;
                    end else begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= ST_IMUL;
                    end
                end
                ST_ITERM: begin
                    raw_reg   <= RAW_W'(p_reg) + RAW_W'(i_cap);
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    ref_reg    <= ref_now;
                    climit_reg <= climit_now;
                    ie_reg     <= IE_W'(ref_now) - IE_W'(il_reg);
                    state_reg  <= ST_CMUL;
                end
                ST_CMUL: begin
                    state_reg <= ST_DUTY;
                end
                ST_DUTY: begin
                    duty_reg    <= duty_now;
                    dsat_reg    <= dsat_now;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_duty_cycle        = duty_reg;
    assign m_current_reference = ref_reg;
    assign m_current_limited   = climit_reg;
    assign m_duty_saturated    = dsat_reg;

endmodule

/* bench/cascaded_voltage_current_loop_top_test.sv */
`timescale 1ns / 1ps

module cascaded_voltage_current_loop_top_test;
    import cvcl_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 152;

    typedef struct {
        logic [32:0]        duty;
        logic signed [15:0] iref;
        logic               limited;
        logic               saturated;
    } tick_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_vout_sample;
    logic signed [15:0] s_inductor_current_sample;
    logic               m_valid;
    logic               m_ready;
    logic [32:0]        m_duty_cycle;
    logic signed [15:0] m_current_reference;
    logic               m_current_limited;
    logic               m_duty_saturated;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Predictor state, kept in step with the block.
    cfg_t               loop_cfg;
    longint             err_sum_model;
    longint             duty_model;
    logic signed [15:0] last_iref;
    tick_result_t       expected_ticks[$];

    int errors;
    int items_sent;
    int results_checked;
    int settings_used;
    int cycle_count;
    bit no_idle;

    cascaded_voltage_current_loop_top u_dut (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .s_valid                   (s_valid),
        .s_ready                   (s_ready),
        .s_vout_sample             (s_vout_sample),
        .s_inductor_current_sample (s_inductor_current_sample),
        .m_valid                   (m_valid),
        .m_ready                   (m_ready),
        .m_duty_cycle              (m_duty_cycle),
        .m_current_reference       (m_current_reference),
        .m_current_limited         (m_current_limited),
        .m_duty_saturated          (m_duty_saturated),
        .cfg_we                    (cfg_we),
        .cfg_index                 (cfg_index),
        .cfg_data                  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cascaded_voltage_current_loop_top_test: errors");
            $finish;
        end
    end

    function automatic tick_result_t predict_tick(input logic signed [15:0] vout,
                                                  input logic signed [15:0] il);
        longint             smax, smin, e, p, raw, lim, iref, ie, adj, nd;
        logic signed [127:0] gain_w, sum_w, iterm_w, cap_w;
        tick_result_t       r;
        smax = (longint'(1) << (ESB - 1)) - 1;
        smin = -smax - 1;
        e = longint'($signed(loop_cfg.voltage_target)) - longint'(vout);

        // The error sum saturates instead of wrapping.
        if (e > 0 && err_sum_model > smax - e)
            err_sum_model = smax;
        else if (e < 0 && err_sum_model < smin - e)
            err_sum_model = smin;
        else
            err_sum_model = err_sum_model + e;

        p = (longint'(loop_cfg.voltage_prop_gain) * e) >>> 16;
        gain_w = {96'd0, loop_cfg.voltage_int_gain_dt};
        sum_w = err_sum_model;
        iterm_w = (gain_w * sum_w) >>> 32;
        cap_w = 1;
        cap_w = cap_w <<< 40;
        if (iterm_w > cap_w)
            iterm_w = cap_w;
        if (iterm_w < -cap_w)
            iterm_w = -cap_w;
        raw = p + longint'(iterm_w);

        lim = longint'(loop_cfg.current_limit);
        iref = raw;
        r.limited = 1'b0;
        if (iref > lim) begin
            iref = lim;
            r.limited = 1'b1;
        end
        if (iref < -lim) begin
            iref = -lim;
            r.limited = 1'b1;
        end

        ie = iref - longint'(il);
        adj = (longint'(loop_cfg.current_gain_dt) * ie) >>> 8;
        nd = duty_model + adj;
        r.saturated = 1'b0;
        if (nd > longint'(DUTY_ONE)) begin
            nd = longint'(DUTY_ONE);
            r.saturated = 1'b1;
        end
        if (nd < 0) begin
            nd = 0;
            r.saturated = 1'b1;
        end
        duty_model = nd;

        r.duty = nd[32:0];
        r.iref = iref[15:0];
        last_iref = r.iref;
        return r;
    endfunction

    function automatic logic signed [15:0] to_sample(input int x);
        if (x > 32767)
            return 16'sh7FFF;
        if (x < -32768)
            return 16'sh8000;
        return x[15:0];
    endfunction

    task automatic send_sample(input logic signed [15:0] vout,
                               input logic signed [15:0] il);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_vout_sample <= vout;
        s_inductor_current_sample <= il;
        do @(posedge aclk); while (!s_ready);
        expected_ticks.push_back(predict_tick(vout, il));
        items_sent++;
    endtask

    // Stops sending and waits until every pending result has been checked.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_VOLTAGE_TARGET:      loop_cfg.voltage_target = data[15:0];
            REG_CURRENT_LIMIT:       loop_cfg.current_limit = data[14:0];
            REG_VOLTAGE_PROP_GAIN:   loop_cfg.voltage_prop_gain = data[23:0];
            REG_VOLTAGE_INT_GAIN_DT: loop_cfg.voltage_int_gain_dt = data;
            REG_CURRENT_GAIN_DT:     loop_cfg.current_gain_dt = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] vt, input logic [31:0] lim,
                              input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kc);
        wait_idle();
        write_reg(REG_VOLTAGE_TARGET, vt);
        write_reg(REG_CURRENT_LIMIT, lim);
        write_reg(REG_VOLTAGE_PROP_GAIN, kp);
        write_reg(REG_VOLTAGE_INT_GAIN_DT, ki);
        write_reg(REG_CURRENT_GAIN_DT, kc);
        settings_used++;
    endtask

    // Result ready: stalls a random number of cycles before each result, unless no_idle is set.
    initial begin : drive_result_ready
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: result item with nothing expected, expected none, actual %0h",
                         $time, m_duty_cycle);
            end else begin
                want = expected_ticks.pop_front();
                results_checked++;
                if (m_duty_cycle !== want.duty)
                    report_mismatch("duty_cycle", want.duty, m_duty_cycle);
                if (m_current_reference !== want.iref)
                    report_mismatch("current_reference", want.iref, m_current_reference);
                if (m_current_limited !== want.limited)
                    report_mismatch("current_limited", want.limited, m_current_limited);
                if (m_duty_saturated !== want.saturated)
                    report_mismatch("duty_saturated", want.saturated, m_duty_saturated);
            end
        end
    end

    task automatic test_reset_settings();
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd3072, 16'sd200);
        send_sample(16'sd100, -16'sd100);
    endtask

    // With unity proportional gain and no integral gain the raw reference equals
    // the voltage error, so the clamp edges can be hit exactly.
    task automatic test_reference_clamp();
        set_config(32'd0, 32'd100, 32'h0001_0000, 32'd0, KC_RESET);
        send_sample(-16'sd100, 16'sd0);
        send_sample(-16'sd101, 16'sd0);
        send_sample(16'sd100, 16'sd0);
        send_sample(16'sd101, 16'sd0);
    endtask

    task automatic test_zero_limit();
        set_config(VT_RESET, 32'd0, KP_RESET, KI_RESET, KC_RESET);
        send_sample(16'sd0, 16'sd1000);
        send_sample(-16'sd32768, -16'sd1000);
    endtask

    // The reference stays at zero, so the duty step is gain * (-il) / 2^8 and a
    // half-scale gain with 512 of current moves the duty by exactly full scale.
    task automatic test_duty_bounds();
        set_config(32'd0, LIM_RESET, 32'd0, 32'd0, 32'h8000_0000);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, -16'sd512);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd0, 16'sd512);
        send_sample(16'sd0, 16'sd1);
    endtask

    task automatic test_field_extremes();
        set_config(32'hFFFF_8000, 32'd32767, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        set_config(32'd32767, 32'd32767, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
    endtask

    task automatic test_unknown_index();
        set_config(VT_RESET, LIM_RESET, KP_RESET, KI_RESET, KC_RESET);
        for (int k = REG_CURRENT_GAIN_DT + 1; k < 8; k++)
            write_reg(k[2:0], $urandom);
        send_sample(-16'sd3000, 16'sd300);
        send_sample(-16'sd3100, -16'sd300);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] lowest,
                                               input logic [31:0] highest,
                                               input logic [31:0] typical_max);
        case ($urandom_range(0, 5))
            0: return lowest;
            1: return highest;
            default: return $urandom_range(0, typical_max);
        endcase
    endfunction

    task automatic test_random_operation();
        logic [31:0]        vt_pick;
        logic signed [15:0] vout;
        logic signed [15:0] il;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: vt_pick = 32'hFFFF_8000;
                1: vt_pick = 32'd32767;
                default: vt_pick = $urandom;
            endcase
            set_config(vt_pick,
                       pick_value(32'd0, 32'd32767, 32'd32767),
                       pick_value(32'd0, 32'h00FF_FFFF, 32'h0004_0000),
                       pick_value(32'd0, 32'hFFFF_FFFF, 32'h0040_0000),
                       pick_value(32'd0, 32'hFFFF_FFFF, 32'h0010_0000));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                no_idle = (phase % 3 == 1) && (n < 40);
                if (phase == 0 && n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                // Mostly a loop settling near its target; the rest is full-range noise.
                if ($urandom_range(0, 9) < 7) begin
                    vout = to_sample(int'($signed(loop_cfg.voltage_target))
                                     + int'($urandom_range(0, 1024)) - 512);
                    il = to_sample(int'(last_iref) + int'($urandom_range(0, 512)) - 256);
                end else begin
                    vout = 16'($urandom);
                    il = 16'($urandom);
                end
                send_sample(vout, il);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_vout_sample = '0;
        s_inductor_current_sample = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        loop_cfg = '{VT_RESET, LIM_RESET, KP_RESET, KI_RESET, KC_RESET};
        err_sum_model = 0;
        duty_model = longint'(DUTY_RESET);
        last_iref = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_settings();
        test_reference_clamp();
        test_zero_limit();
        test_duty_bounds();
        test_field_extremes();
        test_unknown_index();
        test_random_operation();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d samples and compared %0d results over %0d register settings.",
                 items_sent, results_checked, settings_used);
        $display("Covered clamp edges, zero limit, duty bounds, field extremes and ignored writes.");
        if (errors == 0 && expected_ticks.size() == 0)
            $display("cascaded_voltage_current_loop_top_test: clean");
        else
            $display("cascaded_voltage_current_loop_top_test: errors");
        $finish;
    end

endmodule
